// ----- design/multicart_bank_mapper_assert.svh -----
// assertion macros for the multicart bank mapper
// included by the top level, no other dependencies
`ifndef MULTICART_BANK_MAPPER_ASSERT_SVH
`define MULTICART_BANK_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS
// checked every rising clock edge, off while reset is high
`define MBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mapper assertion failed");
// checked every rising clock edge, also during reset
`define MBM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mapper assertion failed");
`else
`define MBM_ASSERT(label, clk, rst, prop)
`define MBM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- design/mbm_pkg.sv -----
// shared types and constants for the multicart bank mapper
// no dependencies
`default_nettype none

package mbm_pkg;

   localparam int PRG_ADDRESS_BITS_DEFAULT = 22;
   localparam int OFFSET_WIDTH = 22;
   localparam int CFG_WIDTH = 9;
   localparam logic [CFG_WIDTH-1:0] PRG_BANKS_RESET = 9'd64;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_PPU   = 2'd2,
      FUNC_RESET = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        hard_reset;
   } req_payload_type;

   typedef struct packed {
      logic [OFFSET_WIDTH-1:0] prg_offset;
      logic                    open_bus;
      logic                    nametable_page;
      logic                    chr_writable;
      logic                    unrom_active;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] latched_address;
      logic [7:0]  latched_data;
      logic        unrom_mode;
   } mapper_state_type;

endpackage

`default_nettype wire

// ----- design/mbm_channels.sv -----
// valid/ready channel interfaces for request and response transactions
// depends on mbm_pkg
`default_nettype none

interface mbm_req_if import mbm_pkg::*; ();
   logic        valid;
   logic        ready;
   func_type    func;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic        hard_reset;

   modport source (output valid, func, address, write_data, hard_reset, input ready);
   modport sink   (input valid, func, address, write_data, hard_reset, output ready);
endinterface

interface mbm_rsp_if import mbm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OFFSET_WIDTH-1:0] prg_offset;
   logic                    open_bus;
   logic                    nametable_page;
   logic                    chr_writable;
   logic                    unrom_active;

   modport source (output valid, prg_offset, open_bus, nametable_page, chr_writable,
                   unrom_active, input ready);
   modport sink   (input valid, prg_offset, open_bus, nametable_page, chr_writable,
                   unrom_active, output ready);
endinterface

`default_nettype wire

// ----- design/mbm_xlate.sv -----
// address translation and next-state logic for one transaction
// depends on mbm_pkg
`default_nettype none

module mbm_xlate import mbm_pkg::*; #(
   parameter int PRG_ADDRESS_BITS = PRG_ADDRESS_BITS_DEFAULT
) (
   input  wire req_payload_type  req,
   input  wire mapper_state_type state_cur,
   input  wire [CFG_WIDTH-1:0]   prg_banks_16k,
   output mapper_state_type      state_nxt,
   output rsp_payload_type       rsp
);

   localparam int MASK_BITS = (PRG_ADDRESS_BITS > OFFSET_WIDTH) ? OFFSET_WIDTH
                                                                : PRG_ADDRESS_BITS;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_MASK =
      {OFFSET_WIDTH{1'b1}} >> (OFFSET_WIDTH - MASK_BITS);

   logic [6:0]              outer;
   logic [7:0]              half_banks;
   logic [7:0]              unrom_bank;
   logic [2:0]              inner;
   logic [OFFSET_WIDTH-1:0] offset;
   logic                    beyond;
   logic                    page;

   always_comb begin
      // 32K bank from latched A4..A0 and A9..A8
      outer = {state_cur.latched_address[9:8], state_cur.latched_address[4:0]};
      half_banks = prg_banks_16k[CFG_WIDTH-1:1];
      beyond = ({1'b0, outer} >= half_banks);
      inner = req.address[14] ? 3'd7 : state_cur.latched_data[2:0];
      unrom_bank = {prg_banks_16k[7:6], 3'b000, inner};

      if (state_cur.unrom_mode) begin
         offset = {unrom_bank, req.address[13:0]};
      end else if (state_cur.latched_address[11]) begin
         // nrom-128: one 16K half mirrored into both cpu halves
         offset = {outer, state_cur.latched_address[12], req.address[13:0]};
      end else begin
         offset = {outer, req.address[14:0]};
      end

      if (state_cur.unrom_mode) begin
         page = req.address[10];
      end else if (state_cur.latched_address[10]) begin
         page = 1'b0;
      end else if (state_cur.latched_address[13]) begin
         page = req.address[11];
      end else begin
         page = req.address[10];
      end

      state_nxt = state_cur;
      rsp.prg_offset = '0;
      rsp.open_bus = 1'b0;
      rsp.nametable_page = 1'b0;

      case (req.func)
         FUNC_WRITE: begin
            if (req.address[15]) begin
               state_nxt.latched_address = req.address;
               state_nxt.latched_data = req.write_data;
            end
         end
         FUNC_READ: begin
            if (req.address[15]) begin
               if (!state_cur.unrom_mode && beyond) begin
                  rsp.open_bus = 1'b1;
               end else begin
                  rsp.prg_offset = offset & OFFSET_MASK;
               end
            end
         end
         FUNC_PPU: begin
            rsp.nametable_page = page;
         end
         FUNC_RESET: begin
            // second chip present: set or toggle the unrom game
            if (prg_banks_16k[3]) begin
               state_nxt.unrom_mode = req.hard_reset ? 1'b1 : ~state_cur.unrom_mode;
            end
            state_nxt.latched_address = '0;
            state_nxt.latched_data = '0;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase

      rsp.chr_writable = ~(~state_nxt.unrom_mode & ~state_nxt.latched_address[10]
                           & state_nxt.latched_address[13]);
      rsp.unrom_active = state_nxt.unrom_mode;
   end

endmodule

`default_nettype wire

// ----- design/multicart_bank_mapper.sv -----
// a request transaction passes the input stage, then the result register, to the response
// throughput: one transaction per cycle unless rsp stalls, set by the single reg-to-reg translate
// reset: synchronous, active high; clears latch, unrom mode and both pipeline stages,
// and sets prg_banks_16k to 64
// depends on mbm_pkg, mbm_channels, mbm_xlate and the assertion header
`default_nettype none

`include "multicart_bank_mapper_assert.svh"

module multicart_bank_mapper import mbm_pkg::*; #(
   parameter int PRG_ADDRESS_BITS = PRG_ADDRESS_BITS_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   mbm_req_if.sink             req_if,
   mbm_rsp_if.source           rsp_if,
   input  wire                 csr_write_enable,
   input  wire [CFG_WIDTH-1:0] csr_write_data
);

   // input stage
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_payload_ff;

   // result stage
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   // mapper state and size register
   mapper_state_type state_ff;
   logic [CFG_WIDTH-1:0] prg_banks_ff;

   mapper_state_type state_in;
   rsp_payload_type  rsp_result;

   logic rsp_load;    // result register free this cycle
   logic s1_advance;  // transaction moves from input stage to result stage
   logic req_take;    // request transaction accepted

   assign rsp_load = ~rsp_valid_ff | rsp_if.ready;
   assign s1_advance = s1_valid_ff & rsp_load;
   // input stage can take a new transaction while the result waits, as long as it drains
   assign req_if.ready = ~s1_valid_ff | rsp_load;
   assign req_take = req_if.valid & req_if.ready;

   assign s1_valid_in = req_take | (s1_valid_ff & ~s1_advance);
   assign rsp_valid_in = s1_advance | (rsp_valid_ff & ~rsp_if.ready);

   // translate: short logic between the input and the result register
   mbm_xlate #(
      .PRG_ADDRESS_BITS (PRG_ADDRESS_BITS)
   ) u_xlate (
      .req           (s1_payload_ff),
      .state_cur     (state_ff),
      .prg_banks_16k (prg_banks_ff),
      .state_nxt     (state_in),
      .rsp           (rsp_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         prg_banks_ff <= PRG_BANKS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // state commits as the transaction leaves the input stage, so order is kept
         if (s1_advance) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            prg_banks_ff <= csr_write_data;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_payload_ff.func       <= req_if.func;
         s1_payload_ff.address    <= req_if.address;
         s1_payload_ff.write_data <= req_if.write_data;
         s1_payload_ff.hard_reset <= req_if.hard_reset;
      end
      if (s1_advance) begin
         rsp_payload_ff <= rsp_result;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.prg_offset     = rsp_payload_ff.prg_offset;
   assign rsp_if.open_bus       = rsp_payload_ff.open_bus;
   assign rsp_if.nametable_page = rsp_payload_ff.nametable_page;
   assign rsp_if.chr_writable   = rsp_payload_ff.chr_writable;
   assign rsp_if.unrom_active   = rsp_payload_ff.unrom_active;

   // open bus only ever comes from a multicart-mode read, which never has an offset
   `MBM_ASSERT(a_open_bus_multi, clock, reset, rsp_valid_ff && rsp_payload_ff.open_bus |-> !rsp_payload_ff.unrom_active && rsp_payload_ff.prg_offset == '0)
   // a stalled input stage keeps its transaction
   `MBM_ASSERT(a_s1_holds, clock, reset, s1_valid_ff && !s1_advance |=> s1_valid_ff)
   // outside system reset, the mode only changes through a reset transaction
   `MBM_ASSERT(a_mode_by_reset, clock, reset, !$stable(state_ff.unrom_mode) && $past(!reset) |-> $past(s1_advance && s1_payload_ff.func == FUNC_RESET))

endmodule

`default_nettype wire
